/* rtl/sequence_gap_loss_monitor_macros.svh */
// Assertion macros shared by the checker of the sequence gap loss monitor.
// Depends on nothing; included by the checker file.
`ifndef SEQUENCE_GAP_LOSS_MONITOR_MACROS_SVH
`define SEQUENCE_GAP_LOSS_MONITOR_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SGLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SGLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/sglm_pkg.sv */
// Package of the sequence gap loss monitor: report kinds, register indexes,
// and the bundle passed from the front part to the back part. No dependencies.
`default_nettype none
package sglm_pkg;
	localparam logic [1:0] KIND_PACKET   = 2'd0;
	localparam logic [1:0] KIND_CHANNEL  = 2'd1;
	localparam logic [1:0] KIND_ACCEPTED = 2'd2;
	localparam logic       REG_MARGIN    = 1'b0;
	localparam logic       REG_VOTES     = 1'b1;
	localparam int         ACC_W         = 14;
	localparam int         CH_W          = 8;
	localparam int         TIME_W        = 48;
	localparam int         CID_W         = 32;
	localparam int         PKT_W         = 31;
	localparam int         CFG_DATA_W    = 13;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [TIME_W-1:0] time_stamp;
		logic [ACC_W-1:0]  accepted_id;
		logic [CID_W-1:0]  channel_id;
		logic [PKT_W-1:0]  packet_number;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CH_W-1:0]   channel;
		logic [31:0]       first_lost;
		logic [31:0]       lost_count;
		logic [TIME_W-1:0] loss_time;
		logic              last;
	} report_t;
endpackage
`default_nettype wire

/* rtl/sglm_front.sv */
// Front part: accepts fragments, drops ignored ones, and queues the rest.
// Depends on sglm_pkg.
`default_nettype none
module sglm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic           ign,
	input  wire sglm_pkg::item_t s_item,
	output logic                q_valid,
	input  wire logic           q_pop,
	output sglm_pkg::item_t     q_item
);
	sglm_pkg::item_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic push;

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready && !ign;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= s_item;
	end
endmodule
`default_nettype wire

/* rtl/sglm_back.sv */
// Back part: read-modify-write of the per-channel state and the windows,
// then report emission one result per cycle while the output accepts it. Depends on sglm_pkg.
`default_nettype none
module sglm_back #(
	parameter int CHANNELS = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [12:0]     margin,
	input  wire logic [7:0]      votes_lim,
	input  wire logic            q_valid,
	output logic                 q_pop,
	input  wire sglm_pkg::item_t q_item,
	output logic                 m_valid,
	input  wire logic            m_ready,
	output sglm_pkg::report_t    m_rep
);
	localparam int CI = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [14:0] AMAX = 15'd16384;
	localparam logic [14:0] AHALF = 15'd8192;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} st_t;
	st_t st_q;

	// Per-channel state words: flag, votes, rollovers, windows.
	typedef struct packed {
		logic        roll;
		logic [7:0]  votes;
		logic [15:0] rolls;
		logic [31:0] id0, id1, id2;
		logic [31:0] aw0, aw1, aw2;
		logic [47:0] ts0, ts1, ts2;
	} chst_t;

	chst_t mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	chst_t rd_q;
	sglm_pkg::item_t it_q;
	logic [30:0] pw_q [3];
	logic [47:0] pt_q [3];
	sglm_pkg::report_t rep_q [3];
	logic [2:0] rv_q;
	logic [1:0] ri_q;

	logic in_rng;
	logic [CI-1:0] cidx;
	assign in_rng = ({24'd0, it_q.channel} < 32'(CHANNELS));
	assign cidx = it_q.channel[CI-1:0];

	chst_t cur, nxt;
	logic [30:0] pw [3];
	logic [47:0] pt [3];
	sglm_pkg::report_t rp [3];
	logic [2:0] rv;
	logic roll;
	logic [8:0] v;
	logic [15:0] rc;
	logic [31:0] acc, cnt;
	logic [15:0] av;
	logic [31:0] pc;

	always_comb begin
		cur = vld_q[cidx] ? rd_q : '0;
		nxt = cur;
		pw = pw_q; pt = pt_q;
		rp[0] = '0; rp[1] = '0; rp[2] = '0;
		rv = '0;
		pc = '0; cnt = '0;
		// Packet window.
		if (it_q.packet_number != '0) begin
			if (pw[0] != '0) begin
				pw[2] = it_q.packet_number; pt[2] = it_q.time_stamp;
				if (pw[0] < pw[1] && pw[1] < pw[2]) begin
					pc = {1'b0, pw[1] - pw[0] - 31'd1};
					if (pc != '0) begin
						rv[0] = 1'b1;
						rp[0] = '{sglm_pkg::KIND_PACKET, 8'd0, {1'b0, pw[0] + 31'd1}, pc, pt[1], 1'b0};
					end
					pw[0] = pw[1]; pw[1] = pw[2]; pt[0] = pt[1]; pt[1] = pt[2];
				end else if (pw[0] < pw[2]) begin
					pw[1] = pw[2]; pt[1] = pt[2];
				end
			end else begin
				pw[0] = pw[1]; pw[1] = pw[2]; pw[2] = it_q.packet_number;
				pt[0] = pt[1]; pt[1] = pt[2]; pt[2] = it_q.time_stamp;
			end
		end
		// Rollover voting.
		roll = cur.roll;
		v = {1'b0, cur.votes};
		rc = cur.rolls;
		av = {2'd0, it_q.accepted_id};
		if (!roll && ({1'b0, av} + {4'd0, margin}) > {2'd0, AMAX}) v = (v < 9'd255) ? v + 9'd1 : v;
		if (roll && av > {3'd0, margin} && av < {1'b0, AHALF}) v = (v < 9'd255) ? v + 9'd1 : v;
		if (!roll && v > {1'b0, votes_lim}) begin
			roll = 1'b1; v = '0;
		end else if (roll && v > {1'b0, votes_lim}) begin
			roll = 1'b0; v = '0; rc = rc + 16'd1;
		end
		nxt.roll = roll; nxt.votes = v[7:0]; nxt.rolls = rc;
		acc = {18'd0, it_q.accepted_id};
		if (roll && {16'd0, av} <= {18'd0, margin, 1'b0}) acc = acc + 32'd16384;
		acc = acc + {2'd0, rc, 14'd0};
		// Channel ID and accepted ID windows.
		if (cur.ts0 != '0) begin
			nxt.ts2 = it_q.time_stamp; nxt.id2 = it_q.channel_id;
			if (nxt.id0 < nxt.id1 && nxt.id1 < nxt.id2) begin
				cnt = nxt.id1 - nxt.id0 - 32'd1;
				if (cnt != '0) begin
					rv[1] = 1'b1;
					rp[1] = '{sglm_pkg::KIND_CHANNEL, it_q.channel, nxt.id0 + 32'd1, cnt, nxt.ts1, 1'b0};
				end
				nxt.ts0 = nxt.ts1; nxt.ts1 = nxt.ts2; nxt.id0 = nxt.id1; nxt.id1 = nxt.id2;
			end else begin
				nxt.ts1 = nxt.ts2; nxt.id1 = nxt.id2;
			end
		end else begin
			nxt.ts0 = nxt.ts1; nxt.ts1 = nxt.ts2; nxt.ts2 = it_q.time_stamp;
			nxt.id0 = nxt.id1; nxt.id1 = nxt.id2; nxt.id2 = it_q.channel_id;
			nxt.aw0 = nxt.aw1; nxt.aw1 = nxt.aw2; nxt.aw2 = acc;
		end
		if (nxt.ts0 != '0) begin
			nxt.aw2 = acc;
			if (nxt.aw0 < nxt.aw1 && nxt.aw1 < nxt.aw2) begin
				cnt = nxt.aw1 - nxt.aw0 - 32'd1;
				if (cnt != '0) begin
					rv[2] = 1'b1;
					rp[2] = '{sglm_pkg::KIND_ACCEPTED, it_q.channel, nxt.aw0 + 32'd1, cnt, nxt.ts1, 1'b0};
				end
				nxt.aw0 = nxt.aw1; nxt.aw1 = nxt.aw2;
			end else begin
				nxt.aw1 = nxt.aw2;
			end
		end
		if (!in_rng) rv[2:1] = '0;
		if (rv[2]) rp[2].last = 1'b1;
		else if (rv[1]) rp[1].last = 1'b1;
		else rp[0].last = 1'b1;
	end

	assign q_pop = q_valid && (st_q == ST_IDLE);
	assign m_valid = (st_q == ST_EMIT) && rv_q[ri_q];
	assign m_rep = rep_q[ri_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			vld_q <= '0;
			rv_q <= '0;
			ri_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pw_q[i] <= '0;
				pt_q[i] <= '0;
			end
		end else begin
			unique case (st_q)
				ST_IDLE: if (q_pop) st_q <= ST_READ;
				ST_READ: begin
					pw_q <= pw; pt_q <= pt;
					if (in_rng) vld_q[cidx] <= 1'b1;
					rv_q <= rv; ri_q <= '0;
					st_q <= (rv != '0) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!rv_q[ri_q] || m_ready) begin
						if (ri_q == 2'd2) begin
							st_q <= ST_IDLE;
							ri_q <= '0;
						end else begin
							ri_q <= ri_q + 2'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= q_item;
			rd_q <= mem[q_item.channel[CI-1:0]];
		end
		if (st_q == ST_READ) begin
			if (in_rng) mem[cidx] <= nxt;
			rep_q <= rp;
		end
	end
endmodule
`default_nettype wire

/* rtl/sequence_gap_loss_monitor.sv */
// Top level of the sequence gap loss monitor: configuration registers,
// front queue and back part. Depends on sglm_pkg, sglm_front, sglm_back.
//
//   channel   direction  payload
//   s_axis    in         fragment fields in s_tdata, address flag in s_tuser
//   m_axis    out        reports in m_tdata, kind in m_tuser, m_tlast
//   cfg       in         register index and value
//
// In the back part an item is popped and its channel state read in the idle state,
// then updated in the read state; when any report is due, three report slots follow
// in turn, and a slot that holds a report waits until the output takes it.
// Reset clears control state and the packet window; channel entries read as
// zero until first written. The front queue holds two items while output stalls.
`default_nettype none
module sequence_gap_loss_monitor #(
	parameter int CHANNELS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata, // channel, time_stamp, accepted_id, channel_id, packet_number
	input  wire logic         s_tuser, // address_nonzero
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [119:0]      m_tdata, // report_channel, first_lost, lost_count, loss_time
	output logic [1:0]        m_tuser, // report_kind
	output logic              m_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [12:0]  cfg_data
);
	logic [12:0] margin_q;
	logic [7:0] votes_q;
	sglm_pkg::item_t it, q_item;
	sglm_pkg::report_t rep;
	logic q_valid, q_pop, ign;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 13'd1000;
			votes_q <= 8'd20;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sglm_pkg::REG_MARGIN: margin_q <= cfg_data;
				sglm_pkg::REG_VOTES: votes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign it.channel = s_tdata[7:0];
	assign it.time_stamp = s_tdata[55:8];
	assign it.accepted_id = s_tdata[69:56];
	assign it.channel_id = s_tdata[101:70];
	assign it.packet_number = s_tdata[132:102];
	assign ign = (s_tdata[7:0] == 8'd0) && s_tuser;

	sglm_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.ign(ign), .s_item(it), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	sglm_back #(.CHANNELS(CHANNELS)) u_back (
		.clk(clk), .arst_n(arst_n), .margin(margin_q), .votes_lim(votes_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.m_valid(m_tvalid), .m_ready(m_tready), .m_rep(rep)
	);

	assign m_tdata = {rep.loss_time, rep.lost_count, rep.first_lost, rep.channel};
	assign m_tuser = rep.kind;
	assign m_tlast = rep.last;
endmodule
`default_nettype wire

/* rtl/sglm_checker.sv */
// Port-level checker of the sequence gap loss monitor and its bind.
// Depends on sequence_gap_loss_monitor_macros.svh and sglm_pkg.
`include "sequence_gap_loss_monitor_macros.svh"
`default_nettype none
module sglm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [119:0] m_tdata,
	input wire logic [1:0]   m_tuser
);
	`SGLM_ASSERT_IMP(a_kind, clk, arst_n, m_tvalid, m_tuser <= sglm_pkg::KIND_ACCEPTED)
	`SGLM_ASSERT_IMP(a_count, clk, arst_n, m_tvalid, m_tdata[71:40] != 32'd0)
	`SGLM_ASSERT_IMP(a_pkt_ch, clk, arst_n, m_tvalid && m_tuser == sglm_pkg::KIND_PACKET, m_tdata[7:0] == 8'd0)
	`SGLM_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
endmodule
bind sequence_gap_loss_monitor sglm_checker u_chk (.*);
`default_nettype wire

/* test/sequence_gap_loss_monitor_test.sv */
// Self-checking testbench of the sequence gap loss monitor: directed and random fragments,
// register settings and output back-pressure, with loss reports predicted in the bench.
// Depends on sglm_pkg and the sequence_gap_loss_monitor RTL.
`default_nettype none
module sequence_gap_loss_monitor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned ACC_SPAN = 64'd16384;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = sglm_pkg::REG_MARGIN;
	logic [12:0] cfg_data = '0;

	sequence_gap_loss_monitor dut (.*);

	always #1 clk = ~clk;

	// Bench copy of the block state.
	logic [12:0] margin_reg;
	logic [7:0] votes_reg;
	bit roll_state [256];
	logic [7:0] vote_state [256];
	logic [15:0] wrap_state [256];
	logic [31:0] cid_win [256][3];
	logic [31:0] acc_win [256][3];
	logic [47:0] ts_win [256][3];
	logic [30:0] pkt_win [3];
	logic [47:0] pkt_ts_win [3];

	sglm_pkg::report_t pending_reports [$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 0;
	bit long_hold = 0;

	// Generator state for well-formed sequences, per channel for IDs and accepted IDs.
	logic [31:0] gen_cid [256];
	logic [13:0] gen_acc [256];
	logic [30:0] gen_pkt = 31'd1;
	logic [47:0] gen_ts = 48'd5;

	task automatic add_report(inout sglm_pkg::report_t rs[$], input logic [1:0] k,
			logic [7:0] ch, logic [31:0] first, logic [31:0] cnt, logic [47:0] t);
		sglm_pkg::report_t r;
		r.kind = k;
		r.channel = ch;
		r.first_lost = first;
		r.lost_count = cnt;
		r.loss_time = t;
		r.last = 1'b0;
		rs.push_back(r);
	endtask

	task automatic predict_reports(input logic [7:0] ch, logic an, logic [47:0] t,
			logic [13:0] raw, logic [31:0] cid, logic [30:0] pkt);
		sglm_pkg::report_t rs[$];
		longint unsigned acc;
		longint unsigned votes;
		bit roll;
		logic [31:0] cnt;
		logic [31:0] accw;
		if (ch == 0 && an)
			return;
		if (pkt != 0) begin
			if (pkt_win[0] != 0) begin
				pkt_win[2] = pkt;
				pkt_ts_win[2] = t;
				if (pkt_win[0] < pkt_win[1] && pkt_win[1] < pkt_win[2]) begin
					cnt = 32'(pkt_win[1]) - 32'(pkt_win[0]) - 1;
					if (cnt != 0)
						add_report(rs, sglm_pkg::KIND_PACKET, 8'd0, 32'(pkt_win[0]) + 1, cnt,
							pkt_ts_win[1]);
					pkt_win[0] = pkt_win[1];
					pkt_win[1] = pkt_win[2];
					pkt_ts_win[0] = pkt_ts_win[1];
					pkt_ts_win[1] = pkt_ts_win[2];
				end else if (pkt_win[0] < pkt_win[2]) begin
					pkt_win[1] = pkt_win[2];
					pkt_ts_win[1] = pkt_ts_win[2];
				end
			end else begin
				pkt_win[0] = pkt_win[1];
				pkt_win[1] = pkt_win[2];
				pkt_win[2] = pkt;
				pkt_ts_win[0] = pkt_ts_win[1];
				pkt_ts_win[1] = pkt_ts_win[2];
				pkt_ts_win[2] = t;
			end
		end
		acc = raw;
		votes = vote_state[ch];
		roll = roll_state[ch];
		if (!roll && acc + margin_reg > ACC_SPAN)
			votes = (votes < 255) ? votes + 1 : 255;
		if (roll && acc > margin_reg && acc < ACC_SPAN / 2)
			votes = (votes < 255) ? votes + 1 : 255;
		if (!roll && votes > votes_reg) begin
			roll = 1;
			votes = 0;
		end
		if (roll && votes > votes_reg) begin
			roll = 0;
			votes = 0;
			wrap_state[ch] = wrap_state[ch] + 16'd1;
		end
		roll_state[ch] = roll;
		vote_state[ch] = 8'(votes);
		if (roll && acc <= 2 * longint'(margin_reg))
			acc += ACC_SPAN;
		accw = 32'(acc + longint'(wrap_state[ch]) * ACC_SPAN);
		if (ts_win[ch][0] != 0) begin
			ts_win[ch][2] = t;
			cid_win[ch][2] = cid;
			if (cid_win[ch][0] < cid_win[ch][1] && cid_win[ch][1] < cid_win[ch][2]) begin
				cnt = cid_win[ch][1] - cid_win[ch][0] - 1;
				if (cnt != 0)
					add_report(rs, sglm_pkg::KIND_CHANNEL, ch, cid_win[ch][0] + 1, cnt,
						ts_win[ch][1]);
				ts_win[ch][0] = ts_win[ch][1];
				ts_win[ch][1] = ts_win[ch][2];
				cid_win[ch][0] = cid_win[ch][1];
				cid_win[ch][1] = cid_win[ch][2];
			end else begin
				ts_win[ch][1] = ts_win[ch][2];
				cid_win[ch][1] = cid_win[ch][2];
			end
		end else begin
			ts_win[ch][0] = ts_win[ch][1];
			ts_win[ch][1] = ts_win[ch][2];
			ts_win[ch][2] = t;
			cid_win[ch][0] = cid_win[ch][1];
			cid_win[ch][1] = cid_win[ch][2];
			cid_win[ch][2] = cid;
			acc_win[ch][0] = acc_win[ch][1];
			acc_win[ch][1] = acc_win[ch][2];
			acc_win[ch][2] = accw;
		end
		if (ts_win[ch][0] != 0) begin
			acc_win[ch][2] = accw;
			if (acc_win[ch][0] < acc_win[ch][1] && acc_win[ch][1] < acc_win[ch][2]) begin
				cnt = acc_win[ch][1] - acc_win[ch][0] - 1;
				if (cnt != 0)
					add_report(rs, sglm_pkg::KIND_ACCEPTED, ch, acc_win[ch][0] + 1, cnt,
						ts_win[ch][1]);
				acc_win[ch][0] = acc_win[ch][1];
				acc_win[ch][1] = acc_win[ch][2];
			end else begin
				acc_win[ch][1] = acc_win[ch][2];
			end
		end
		if (rs.size() > 0)
			rs[rs.size() - 1].last = 1'b1;
		foreach (rs[i])
			pending_reports.push_back(rs[i]);
	endtask

	task automatic send_fragment(input logic [7:0] ch, logic an, logic [47:0] t,
			logic [13:0] acc, logic [31:0] cid, logic [30:0] pkt);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= an;
		s_tdata <= {3'b000, pkt, cid, acc, t, ch};
		do @(posedge clk); while (!s_tready);
		predict_reports(ch, an, t, acc, cid, pkt);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sglm_pkg::REG_MARGIN)
			margin_reg = value;
		else
			votes_reg = value[7:0];
	endtask

	task automatic set_registers(input logic [12:0] margin, logic [7:0] votes);
		wait_drained();
		write_register(sglm_pkg::REG_MARGIN, margin);
		write_register(sglm_pkg::REG_VOTES, {5'd0, votes});
	endtask

	// Mostly well-formed per-channel sequences, with gaps, breaks and noise.
	task automatic send_sequenced(input int count);
		logic [7:0] ch;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_fragment(8'($urandom), 1'($urandom), 48'({$urandom, $urandom}),
					14'($urandom), $urandom, 31'($urandom));
				continue;
			end
			case ($urandom_range(0, 4))
				0: ch = 8'd0;
				1: ch = 8'd1;
				2: ch = 8'd2;
				3: ch = 8'd255;
				default: ch = 8'($urandom);
			endcase
			gen_ts = gen_ts + $urandom_range(1, 1000);
			gen_cid[ch] = gen_cid[ch] + (($urandom_range(0, 3) == 0) ?
				$urandom_range(2, 9) : 1);
			if (pick < 13)
				gen_cid[ch] = $urandom;
			gen_acc[ch] = gen_acc[ch] + 14'($urandom_range(1, 900));
			if ($urandom_range(0, 2) == 0)
				gen_pkt = gen_pkt + 31'(($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 1);
			send_fragment(ch, 1'b0, (pick < 16) ? 48'd0 : gen_ts, gen_acc[ch], gen_cid[ch],
				(pick > 90) ? 31'd0 : gen_pkt);
		end
	endtask

	task automatic test_directed();
		send_fragment(8'd0, 1'b1, 48'd77, 14'd5, 32'd9, 31'd3);
		send_fragment(8'd1, 1'b0, 48'd0, 14'd0, 32'd0, 31'd0);
		for (int i = 0; i < 4; i++)
			send_fragment(8'd1, 1'b0, 48'd100 + 48'(i), 14'd10 + 14'(3 * i), 32'd5 + 32'(4 * i),
				31'd1 + 31'(2 * i));
		send_fragment(8'd1, 1'b0, 48'd200, 14'd1, 32'd1, 31'd2);
		send_fragment(8'd1, 1'b0, 48'd201, 14'd2, 32'd40, 31'd1);
		for (int i = 0; i < 4; i++)
			send_fragment(8'd255, 1'b0, {48{1'b1}} - 48'(i), {14{1'b1}} - 14'(i),
				{32{1'b1}} - 32'd9 + 32'(4 * i), {31{1'b1}} - 31'd8 + 31'(3 * i));
		send_fragment(8'd0, 1'b0, 48'd1, 14'd0, 32'd0, {31{1'b1}});
		for (int i = 0; i < 4; i++)
			send_fragment(8'd0, 1'b0, 48'd50 + 48'(i), 14'd16000, 32'(3 * i), 31'd0);
		send_fragment(8'd0, 1'b1, 48'd9, 14'd3, 32'd100, 31'd100);
	endtask

	task automatic test_rollover();
		logic [13:0] a;
		set_registers(13'd600, 8'd1);
		a = 14'd15000;
		for (int i = 0; i < 30; i++) begin
			a = a + 14'd300;
			gen_ts = gen_ts + 48'd7;
			send_fragment(8'd3, 1'b0, gen_ts, a, 32'(i), 31'd0);
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		long_hold = 1;
		no_idle = 1;
		send_sequenced(30);
		no_idle = 0;
		wait_drained();
	endtask

	task automatic test_random_settings();
		set_registers(13'd0, 8'd0);
		send_sequenced(60);
		set_registers(13'd8191, 8'd254);
		send_sequenced(60);
		set_registers(13'd3000, 8'd2);
		no_idle = 1;
		send_sequenced(40);
		no_idle = 0;
		set_registers(13'($urandom), 8'($urandom_range(0, 254)));
		send_sequenced(70);
		set_registers(13'd1000, 8'd20);
		send_sequenced(30);
	endtask

	initial begin
		margin_reg = 13'd1000;
		votes_reg = 8'd20;
		foreach (roll_state[c]) begin
			roll_state[c] = 0;
			vote_state[c] = '0;
			wrap_state[c] = '0;
			gen_cid[c] = '0;
			gen_acc[c] = '0;
			for (int k = 0; k < 3; k++) begin
				cid_win[c][k] = '0;
				acc_win[c][k] = '0;
				ts_win[c][k] = '0;
			end
		end
		for (int k = 0; k < 3; k++) begin
			pkt_win[k] = '0;
			pkt_ts_win[k] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_rollover();
		test_backpressure();
		test_random_settings();
		wait_drained();
		if (errors == 0)
			$display("PASS sequence_gap_loss_monitor");
		else
			$display("FAIL sequence_gap_loss_monitor");
		$finish;
	end

	initial begin
		int w;
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end
			w = no_idle ? 0 : $urandom_range(0, 16);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && !long_hold);
		end
	end

	always @(posedge clk) begin
		sglm_pkg::report_t exp_r;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL sequence_gap_loss_monitor");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report, actual %h kind %0d last %0b", $realtime,
					m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				exp_r = pending_reports.pop_front();
				if (m_tuser !== exp_r.kind || m_tdata[7:0] !== exp_r.channel ||
						m_tdata[39:8] !== exp_r.first_lost ||
						m_tdata[71:40] !== exp_r.lost_count ||
						m_tdata[119:72] !== exp_r.loss_time || m_tlast !== exp_r.last) begin
					$display("%0t: mismatch, expected kind %0d ch %0d first %0d count %0d time %0d last %0b",
						$realtime, exp_r.kind, exp_r.channel, exp_r.first_lost,
						exp_r.lost_count, exp_r.loss_time, exp_r.last);
					$display("%0t:           actual kind %0d ch %0d first %0d count %0d time %0d last %0b",
						$realtime, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[71:40],
						m_tdata[119:72], m_tlast);
					errors++;
				end
			end
		end
	end
endmodule
`default_nettype wire
